@@ hdl/dqpb_pkg.sv @@
// ----------------------------------------------------------------------------
// dqpb_pkg
// Shared types and constants of the DNS query packet builder: channel
// payloads, controller/datapath command and status, register indexes.
// ----------------------------------------------------------------------------
package dqpb_pkg;

	// label buffer geometry
	localparam int MAX_LABEL   = 63;
	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W      = 6;
	localparam int LEN_W       = 6;
	localparam int CNT_W       = 6;

	// byte positions of the fixed sequences
	localparam logic [CNT_W-1:0] HDR_LAST  = CNT_W'(11);
	localparam logic [CNT_W-1:0] TERM_LAST = CNT_W'(4);

	// question count written into the header
	localparam logic [15:0] QD_COUNT = 16'h0001;

	// label separator
	localparam logic [7:0] CHAR_DOT = 8'h2e;

	// input opcodes
	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_END  = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_TRANSACTION_ID = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_FLAGS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUERY_TYPE     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_QUERY_CLASS    = 2'd3;

	// configuration reset values
	localparam logic [15:0] RST_TRANSACTION_ID = 16'h4242;
	localparam logic [15:0] RST_HEADER_FLAGS   = 16'h0100;
	localparam logic [15:0] RST_QUERY_TYPE     = 16'h0001;
	localparam logic [15:0] RST_QUERY_CLASS    = 16'h0001;

	// byte source select
	localparam logic [1:0] SEL_HDR  = 2'd0;
	localparam logic [1:0] SEL_LEN  = 2'd1;
	localparam logic [1:0] SEL_DATA = 2'd2;
	localparam logic [1:0] SEL_TERM = 2'd3;

	typedef struct packed {
		logic       opcode;
		logic [7:0] name_char;
	} dqpb_in_t;

	typedef struct packed {
		logic [7:0] byte_first;
		logic [7:0] byte_second;
		logic       pair_valid;
		logic       label_overflow;
		logic       run_last;
		logic       packet_end;
	} dqpb_out_t;

	// controller to datapath
	typedef struct packed {
		logic              accept;
		logic              byte_valid;
		logic [1:0]        byte_sel;
		logic [CNT_W-1:0]  cnt;
		logic              last;
		logic [ADDR_W-1:0] rd_addr;
		logic              clear_label;
		logic              close_query;
	} dqpb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic             hdr_needed;
		logic [LEN_W-1:0] label_len;
		logic             byte_take;
	} dqpb_stat_t;

endpackage

@@ hdl/dqpb_ram.sv @@
// ----------------------------------------------------------------------------
// dqpb_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module dqpb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

@@ hdl/dqpb_ctrl.sv @@
// ----------------------------------------------------------------------------
// dqpb_ctrl
// Packet builder sequencer: takes an input transaction, walks the header,
// length byte, label data and trailer one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module dqpb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 name_valid,
	output logic                 name_ready,
	input  dqpb_pkg::dqpb_in_t   name_item,
	input  dqpb_pkg::dqpb_stat_t stat,
	output dqpb_pkg::dqpb_cmd_t  cmd
);
	import dqpb_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_HDR  = 3'd1;
	localparam logic [2:0] ST_LEN  = 3'd2;
	localparam logic [2:0] ST_DATA = 3'd3;
	localparam logic [2:0] ST_TERM = 3'd4;

	logic [2:0]        state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              flush_q, flush_d;
	logic              end_q, end_d;
	logic              accept;
	logic              is_dot;
	logic              last;
	logic              data_last;
	logic [ADDR_W-1:0] rd_addr;
	logic [1:0]        byte_sel;

	assign name_ready = (state_q == ST_IDLE);
	assign accept     = name_valid & name_ready;
	assign is_dot     = (name_item.opcode == OP_CHAR) && (name_item.name_char == CHAR_DOT);
	assign data_last  = (cnt_q == CNT_W'(stat.label_len - LEN_W'(1)));

	// next state and byte sequencing
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		flush_d  = flush_q;
		end_d    = end_q;
		last     = 1'b0;
		rd_addr  = '0;
		byte_sel = SEL_HDR;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					end_d   = (name_item.opcode == OP_END);
					flush_d = is_dot || ((name_item.opcode == OP_END) && (stat.label_len != '0));
					cnt_d   = '0;
					if (stat.hdr_needed) begin
						state_d = ST_HDR;
					end else if (flush_d) begin
						state_d = ST_LEN;
					end else if (end_d) begin
						state_d = ST_TERM;
					end
				end
			end
			ST_HDR: begin
				byte_sel = SEL_HDR;
				last     = (cnt_q == HDR_LAST) && !flush_q && !end_q;
				if (stat.byte_take) begin
					if (cnt_q == HDR_LAST) begin
						cnt_d = '0;
						if (flush_q) begin
							state_d = ST_LEN;
						end else if (end_q) begin
							state_d = ST_TERM;
						end else begin
							state_d = ST_IDLE;
						end
					end else begin
						cnt_d = cnt_q + CNT_W'(1);
					end
				end
			end
			ST_LEN: begin
				byte_sel = SEL_LEN;
				last     = (stat.label_len == '0) && !end_q;
				if (stat.byte_take) begin
					cnt_d = '0;
					if (stat.label_len != '0) begin
						state_d = ST_DATA;
					end else if (end_q) begin
						state_d = ST_TERM;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_DATA: begin
				byte_sel = SEL_DATA;
				last     = data_last && !end_q;
				// address one ahead so the registered read lines up
				rd_addr  = stat.byte_take ? ADDR_W'(cnt_q + CNT_W'(1)) : ADDR_W'(cnt_q);
				if (stat.byte_take) begin
					if (data_last) begin
						cnt_d   = '0;
						state_d = end_q ? ST_TERM : ST_IDLE;
					end else begin
						cnt_d = cnt_q + CNT_W'(1);
					end
				end
			end
			ST_TERM: begin
				byte_sel = SEL_TERM;
				last     = (cnt_q == TERM_LAST);
				if (stat.byte_take) begin
					if (cnt_q == TERM_LAST) begin
						cnt_d   = '0;
						state_d = ST_IDLE;
					end else begin
						cnt_d = cnt_q + CNT_W'(1);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			flush_q <= 1'b0;
			end_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			flush_q <= flush_d;
			end_q   <= end_d;
		end
	end

	// command to datapath
	always_comb begin
		cmd             = '0;
		cmd.accept      = accept;
		cmd.byte_valid  = (state_q != ST_IDLE);
		cmd.byte_sel    = byte_sel;
		cmd.cnt         = cnt_q;
		cmd.last        = last;
		cmd.rd_addr     = rd_addr;
		cmd.clear_label = (state_q != ST_IDLE) && stat.byte_take && last && (flush_q || end_q);
		cmd.close_query = (state_q != ST_IDLE) && stat.byte_take && last && end_q;
	end

endmodule

@@ hdl/dqpb_datapath.sv @@
// ----------------------------------------------------------------------------
// dqpb_datapath
// Configuration registers, label buffer and label state, byte source mux,
// byte pairing and the result output register.
// ----------------------------------------------------------------------------
module dqpb_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dqpb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [15:0]                          cfg_data,
	input  dqpb_pkg::dqpb_in_t                   name_item,
	output logic                                 pkt_valid,
	input  logic                                 pkt_ready,
	output dqpb_pkg::dqpb_out_t                  pkt_item,
	input  dqpb_pkg::dqpb_cmd_t                  cmd,
	output dqpb_pkg::dqpb_stat_t                 stat
);
	import dqpb_pkg::*;

	logic [15:0]       txn_id_q;
	logic [15:0]       flags_q;
	logic [15:0]       qtype_q;
	logic [15:0]       qclass_q;
	logic [LEN_W-1:0]  label_len_q;
	logic              ovf_q;
	logic              open_q;
	logic              end_item_q;
	logic              half_valid_q;
	logic [7:0]        half_byte_q;
	logic              half_flag_q;
	logic              pkt_valid_q;
	dqpb_out_t         pkt_item_q;
	logic              store_char;
	logic              ram_we;
	logic [7:0]        ram_rdata;
	logic [7:0]        cur_byte;
	logic              cur_flag;
	logic              emit;
	logic              out_free;
	logic              take;

	// configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			txn_id_q <= RST_TRANSACTION_ID;
			flags_q  <= RST_HEADER_FLAGS;
			qtype_q  <= RST_QUERY_TYPE;
			qclass_q <= RST_QUERY_CLASS;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TRANSACTION_ID: txn_id_q <= cfg_data;
				REG_HEADER_FLAGS:   flags_q  <= cfg_data;
				REG_QUERY_TYPE:     qtype_q  <= cfg_data;
				REG_QUERY_CLASS:    qclass_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// label character buffering
	assign store_char = cmd.accept && (name_item.opcode == OP_CHAR)
		&& (name_item.name_char != CHAR_DOT);
	assign ram_we     = store_char && (label_len_q < LEN_W'(MAX_LABEL));

	dqpb_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH)
	) u_label_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ADDR_W'(label_len_q)),
		.wdata (name_item.name_char),
		.raddr (cmd.rd_addr),
		.rdata (ram_rdata)
	);

	// label and query state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			label_len_q <= '0;
			ovf_q       <= 1'b0;
			open_q      <= 1'b0;
			end_item_q  <= 1'b0;
		end else begin
			if (cmd.accept) begin
				open_q     <= 1'b1;
				end_item_q <= (name_item.opcode == OP_END);
			end else if (cmd.close_query) begin
				open_q <= 1'b0;
			end
			if (ram_we) begin
				label_len_q <= label_len_q + LEN_W'(1);
			end else if (store_char) begin
				ovf_q <= 1'b1;
			end else if (cmd.clear_label) begin
				label_len_q <= '0;
				ovf_q       <= 1'b0;
			end
		end
	end

	// byte source mux
	always_comb begin
		cur_byte = 8'h00;
		cur_flag = 1'b0;
		case (cmd.byte_sel)
			SEL_HDR: begin
				case (cmd.cnt)
					CNT_W'(0): cur_byte = txn_id_q[15:8];
					CNT_W'(1): cur_byte = txn_id_q[7:0];
					CNT_W'(2): cur_byte = flags_q[15:8];
					CNT_W'(3): cur_byte = flags_q[7:0];
					CNT_W'(4): cur_byte = QD_COUNT[15:8];
					CNT_W'(5): cur_byte = QD_COUNT[7:0];
					default:   cur_byte = 8'h00;
				endcase
			end
			SEL_LEN: begin
				cur_byte = 8'(label_len_q);
				cur_flag = ovf_q;
			end
			SEL_DATA: begin
				cur_byte = ram_rdata;
				cur_flag = ovf_q;
			end
			SEL_TERM: begin
				case (cmd.cnt)
					CNT_W'(1): cur_byte = qtype_q[15:8];
					CNT_W'(2): cur_byte = qtype_q[7:0];
					CNT_W'(3): cur_byte = qclass_q[15:8];
					CNT_W'(4): cur_byte = qclass_q[7:0];
					default:   cur_byte = 8'h00;
				endcase
			end
			default: ;
		endcase
	end

	// byte pairing handshake
	assign out_free = !pkt_valid_q || pkt_ready;
	assign emit     = half_valid_q || cmd.last;
	assign take     = cmd.byte_valid && (!emit || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_valid_q <= 1'b0;
			pkt_valid_q  <= 1'b0;
		end else begin
			if (take && emit) begin
				half_valid_q <= 1'b0;
				pkt_valid_q  <= 1'b1;
			end else begin
				if (take) begin
					half_valid_q <= 1'b1;
				end
				if (pkt_ready) begin
					pkt_valid_q <= 1'b0;
				end
			end
		end
	end

	// pairing payload
	always_ff @(posedge clk) begin
		if (take && !emit) begin
			half_byte_q <= cur_byte;
			half_flag_q <= cur_flag;
		end
		if (take && emit) begin
			if (half_valid_q) begin
				pkt_item_q.byte_first     <= half_byte_q;
				pkt_item_q.byte_second    <= cur_byte;
				pkt_item_q.pair_valid     <= 1'b1;
				pkt_item_q.label_overflow <= half_flag_q | cur_flag;
			end else begin
				pkt_item_q.byte_first     <= cur_byte;
				pkt_item_q.byte_second    <= 8'h00;
				pkt_item_q.pair_valid     <= 1'b0;
				pkt_item_q.label_overflow <= cur_flag;
			end
			pkt_item_q.run_last   <= cmd.last;
			pkt_item_q.packet_end <= cmd.last & end_item_q;
		end
	end

	assign pkt_valid = pkt_valid_q;
	assign pkt_item  = pkt_item_q;

	// status to controller
	always_comb begin
		stat            = '0;
		stat.hdr_needed = !open_q;
		stat.label_len  = label_len_q;
		stat.byte_take  = take;
	end

endmodule

@@ hdl/dns_query_packet_builder.sv @@
// ----------------------------------------------------------------------------
// dns_query_packet_builder
// Builds a DNS query packet from a hostname streamed one character at a time.
// ----------------------------------------------------------------------------
// Usage:
//   name channel (name_valid/name_ready/name_item): one hostname character or
//   the end marker per transaction. pkt channel (pkt_valid/pkt_ready/pkt_item):
//   packet bytes, up to two per transaction, run_last on the last one of an input
//   transaction and packet_end on the last one of the packet. cfg channel
//   writes the id, flags, type and class words; write it only while idle.
//   Flow: the sequencer makes one packet byte per cycle unless the output
//   register stalls it; name_ready stays low after an input transaction is
//   taken until all of its bytes are taken (12 for the header, label length
//   + 1 for a flushed label, 5 for the trailer); a character that causes no
//   byte leaves name_ready high. Two bytes, or the last byte of an input
//   transaction, make one result in the output register.
//   A finished result sits in the output register, so the next character is
//   taken while it waits. When pkt_ready is low the sequencer holds a byte
//   that would complete a result until the output register frees up.
//   Reset: configuration returns to 0x4242/0x0100/1/1, the label is empty and
//   the next transaction opens a new packet with its header. The label buffer
//   content is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module dns_query_packet_builder (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dqpb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                    cfg_data,
	input  logic                           name_valid,
	output logic                           name_ready,
	input  dqpb_pkg::dqpb_in_t             name_item,
	output logic                           pkt_valid,
	input  logic                           pkt_ready,
	output dqpb_pkg::dqpb_out_t            pkt_item
);
	import dqpb_pkg::*;

	dqpb_cmd_t  cmd;
	dqpb_stat_t stat;

	// sequencer
	dqpb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.name_valid (name_valid),
		.name_ready (name_ready),
		.name_item  (name_item),
		.stat       (stat),
		.cmd        (cmd)
	);

	// datapath
	dqpb_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.name_item (name_item),
		.pkt_valid (pkt_valid),
		.pkt_ready (pkt_ready),
		.pkt_item  (pkt_item),
		.cmd       (cmd),
		.stat      (stat)
	);

	// packet end only on the last result of a transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid && pkt_item.packet_end |-> pkt_item.run_last)
		else $error("packet_end without run_last");

	// a single byte result only closes a transaction and carries a zero second byte
	assert property (@(posedge clk) disable iff (!arst_n)
		pkt_valid && !pkt_item.pair_valid |-> pkt_item.run_last && (pkt_item.byte_second == 8'h00))
		else $error("unpaired byte inside a transaction");

	// no new transaction while a byte sequence is running
	assert property (@(posedge clk) disable iff (!arst_n)
		name_ready |-> !cmd.byte_valid)
		else $error("input taken during byte sequence");

	// a taken end marker leaves the label empty once its bytes are done
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.close_query |=> stat.hdr_needed && (stat.label_len == '0))
		else $error("query not closed after end marker");

endmodule
